@@ rtl/sss_pkg.sv @@
// Shared types and constants for the sphere sun shading core.
// Used by sss_sqrt, sss_div and sphere_sun_shading_core; no dependencies.
package sss_pkg;

    localparam int RAD_W     = 15;   // radius register
    localparam int SUN_W     = 12;   // sun vector components
    localparam int CFG_W     = 15;   // widest configuration register
    localparam int OFS_W     = 7;    // col / row offsets
    localparam int RSQ_W     = 2 * RAD_W;
    localparam int SQ_W      = 32;   // square root working width
    localparam int SQ_STAGES = 16;   // two radicand bits per stage
    localparam int D_W       = 15;   // depth result
    localparam int PA_W      = D_W + 1 + SUN_W;
    localparam int PB_W      = OFS_W + 1 + SUN_W;
    localparam int NUM_W     = PA_W + 1;
    localparam int DIV_W     = NUM_W - 2;   // magnitude of a positive numerator
    localparam int LANES     = 4;
    localparam int LIGHT_W   = 8;
    localparam int LIGHT_LSB = 2;
    localparam int RAD_MIN   = 2;

    typedef enum logic [1:0] {
        REG_RADIUS     = 2'd0,
        REG_SUN_VIEW   = 2'd1,
        REG_SUN_HORIZ  = 2'd2,
        REG_SUN_VERT   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic             in_disc;
        logic [OFS_W-1:0] col;
        logic [OFS_W-1:0] row;
    } t_pix;

    typedef struct packed {
        logic en;       // advance all stages
    } t_ctl;

endpackage

@@ rtl/sphere_sun_shading_core.sv @@
// Sphere sun shading: one quadrant pixel in, four mirrored light values out.
// Stages: input reg, disc test, 16 root stages, products, sums,
// 27 divider stages. Throughput one request per cycle; a stall on the output
// freezes the whole pipeline. Synchronous active-low reset clears valids and
// loads radius 100 and sun vector (0, 1024, 0). Depends on sss_pkg.
module sphere_sun_shading_core #(
    parameter int HALF_SIZE = 120
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [1:0]                  i_cfg_idx,
    input  logic [sss_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [sss_pkg::OFS_W-1:0]   i_col,
    input  logic [sss_pkg::OFS_W-1:0]   i_row,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_write_pp,
    output logic [7:0]                  o_light_pp,
    output logic                        o_write_pn,
    output logic [7:0]                  o_light_pn,
    output logic                        o_write_np,
    output logic [7:0]                  o_light_np,
    output logic                        o_write_nn,
    output logic [7:0]                  o_light_nn
);
    localparam int HS_W = $clog2(HALF_SIZE + 1) + 1;
    localparam int RW   = sss_pkg::RAD_W;
    localparam int SW   = sss_pkg::SUN_W;
    localparam int OW   = sss_pkg::OFS_W;
    localparam int L    = sss_pkg::LANES;

    sss_pkg::t_ctl ctl;

    logic [RW-1:0]            r_radius;
    logic signed [SW-1:0]     r_sun_view;
    logic signed [SW-1:0]     r_sun_horiz;
    logic signed [SW-1:0]     r_sun_vert;
    logic [sss_pkg::RSQ_W-1:0] r_rsq;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= RW'(100);
            r_sun_view  <= '0;
            r_sun_horiz <= SW'(1024);
            r_sun_vert  <= '0;
        end else if (i_cfg_we) begin
            case (sss_pkg::t_reg_idx'(i_cfg_idx))
                sss_pkg::REG_RADIUS: begin
                    if (i_cfg_wdata[RW-1:0] >= RW'(sss_pkg::RAD_MIN))
                        r_radius <= i_cfg_wdata[RW-1:0];
                end
                sss_pkg::REG_SUN_VIEW:  r_sun_view  <= i_cfg_wdata[SW-1:0];
                sss_pkg::REG_SUN_HORIZ: r_sun_horiz <= i_cfg_wdata[SW-1:0];
                sss_pkg::REG_SUN_VERT:  r_sun_vert  <= i_cfg_wdata[SW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsq <= r_radius * r_radius;
    end

    // global advance: hold everything while a finished result is stalled
    assign ctl.en  = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    // input register
    logic          r_in_v;
    logic [OW-1:0] r_in_col;
    logic [OW-1:0] r_in_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (ctl.en) begin
            r_in_v <= i_valid;
        end
        if (ctl.en) begin
            r_in_col <= i_col;
            r_in_row <= i_row;
        end
    end

    // disc test and radicand
    logic                      ovf;
    logic [2*OW-1:0]           rowsq;
    logic [2*OW-1:0]           colsq;
    logic signed [sss_pkg::SQ_W-1:0] rad;
    logic                      in_disc;
    logic [sss_pkg::SQ_W-1:0]  r_fr_x;
    logic                      r_fr_v;
    sss_pkg::t_pix             r_fr_side;

    always_comb begin
        ovf    = (HS_W'(r_in_col) >= HS_W'(HALF_SIZE)) ||
                 (HS_W'(r_in_row) >= HS_W'(HALF_SIZE));
        rowsq  = r_in_row * r_in_row;
        colsq  = r_in_col * r_in_col;
        rad    = $signed(sss_pkg::SQ_W'(r_rsq)) - $signed(sss_pkg::SQ_W'(rowsq))
                 - $signed(sss_pkg::SQ_W'(colsq));
        in_disc = !ovf && !rad[sss_pkg::SQ_W-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fr_v <= 1'b0;
        end else if (ctl.en) begin
            r_fr_v <= r_in_v;
        end
        if (ctl.en) begin
            r_fr_x            <= in_disc ? rad : '0;
            r_fr_side.in_disc <= in_disc;
            r_fr_side.col     <= r_in_col;
            r_fr_side.row     <= r_in_row;
        end
    end

    logic                    sq_v;
    logic [sss_pkg::D_W-1:0] sq_root;
    sss_pkg::t_pix           sq_side;

    sss_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_valid (r_fr_v),
        .i_x     (r_fr_x),
        .i_side  (r_fr_side),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // products
    logic                           r_pr_v;
    logic signed [sss_pkg::PA_W-1:0] r_pr_a;
    logic signed [sss_pkg::PB_W-1:0] r_pr_b;
    logic signed [sss_pkg::PB_W-1:0] r_pr_c;
    sss_pkg::t_pix                  r_pr_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pr_v <= 1'b0;
        end else if (ctl.en) begin
            r_pr_v <= sq_v;
        end
        if (ctl.en) begin
            r_pr_a    <= $signed({1'b0, sq_root}) * r_sun_view;
            r_pr_b    <= $signed({1'b0, sq_side.row}) * r_sun_vert;
            r_pr_c    <= $signed({1'b0, sq_side.col}) * r_sun_horiz;
            r_pr_side <= sq_side;
        end
    end

    // four mirrored numerators; drop disabled or nonpositive ones to zero
    logic signed [sss_pkg::NUM_W-1:0] a_x;
    logic signed [sss_pkg::NUM_W-1:0] b_x;
    logic signed [sss_pkg::NUM_W-1:0] c_x;
    logic signed [sss_pkg::NUM_W-1:0] num [0:L-1];
    logic                             ena [0:L-1];
    logic                             r_sm_v;
    logic [sss_pkg::DIV_W-1:0]        r_sm_dvd [0:L-1];

    always_comb begin
        a_x    = sss_pkg::NUM_W'(r_pr_a);
        b_x    = sss_pkg::NUM_W'(r_pr_b);
        c_x    = sss_pkg::NUM_W'(r_pr_c);
        num[0] = a_x + b_x + c_x;
        num[1] = a_x - b_x + c_x;
        num[2] = a_x + b_x - c_x;
        num[3] = a_x - b_x - c_x;
        ena[0] = r_pr_side.in_disc;
        ena[1] = r_pr_side.in_disc && (r_pr_side.row != '0);
        ena[2] = r_pr_side.in_disc && (r_pr_side.col != '0);
        ena[3] = r_pr_side.in_disc && (r_pr_side.row != '0) && (r_pr_side.col != '0);
    end

    for (genvar l = 0; l < L; l++) begin : g_num
        always_ff @(posedge i_clk) begin
            if (ctl.en) begin
                r_sm_dvd[l] <= (ena[l] && !num[l][sss_pkg::NUM_W-1])
                               ? num[l][sss_pkg::DIV_W-1:0] : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sm_v <= 1'b0;
        end else if (ctl.en) begin
            r_sm_v <= r_pr_v;
        end
    end

    logic [sss_pkg::DIV_W-1:0] quo [0:L-1];

    sss_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_valid   (r_sm_v),
        .i_dvd     (r_sm_dvd),
        .i_divisor (r_radius),
        .o_valid   (o_valid),
        .o_quo     (quo)
    );

    localparam int LH = sss_pkg::LIGHT_LSB + sss_pkg::LIGHT_W - 1;

    assign o_write_pp = |quo[0];
    assign o_light_pp = quo[0][LH:sss_pkg::LIGHT_LSB];
    assign o_write_pn = |quo[1];
    assign o_light_pn = quo[1][LH:sss_pkg::LIGHT_LSB];
    assign o_write_np = |quo[2];
    assign o_light_np = quo[2][LH:sss_pkg::LIGHT_LSB];
    assign o_write_nn = |quo[3];
    assign o_light_nn = quo[3][LH:sss_pkg::LIGHT_LSB];

    a_radius_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_radius >= RW'(sss_pkg::RAD_MIN))
        else $error("radius below minimum");

    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled without a pending result");

    a_light_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && ((o_light_pp != '0 && !o_write_pp) || (o_light_nn != '0 && !o_write_nn))
        |-> 1'b0)
        else $error("light without write flag");

    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pr_v && ctl.en && !r_pr_side.in_disc |=> r_sm_dvd[0] == '0 && r_sm_dvd[3] == '0)
        else $error("outside pixel produced a numerator");

endmodule

@@ rtl/sss_sqrt.sv @@
// Pipelined floor square root, one bit-pair per register stage.
// Depends on sss_pkg; carries pixel sideband and valid alongside.
module sss_sqrt (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  sss_pkg::t_ctl           i_ctl,
    input  logic                    i_valid,
    input  logic [sss_pkg::SQ_W-1:0] i_x,
    input  sss_pkg::t_pix           i_side,
    output logic                    o_valid,
    output logic [sss_pkg::D_W-1:0] o_root,
    output sss_pkg::t_pix           o_side
);
    localparam int N = sss_pkg::SQ_STAGES;

    logic [sss_pkg::SQ_W-1:0] r_x    [0:N-1];
    logic [sss_pkg::SQ_W-1:0] r_y    [0:N-1];
    logic                     r_v    [0:N-1];
    sss_pkg::t_pix            r_side [0:N-1];

    logic [sss_pkg::SQ_W-1:0] w_x    [0:N];
    logic [sss_pkg::SQ_W-1:0] w_y    [0:N];
    logic                     w_v    [0:N];
    sss_pkg::t_pix            w_side [0:N];

    assign w_x[0]    = i_x;
    assign w_y[0]    = '0;
    assign w_v[0]    = i_valid;
    assign w_side[0] = i_side;

    for (genvar g = 0; g < N; g++) begin : g_stage
        localparam logic [sss_pkg::SQ_W-1:0] M = 32'h4000_0000 >> (2 * g);
        logic [sss_pkg::SQ_W-1:0] b;
        logic [sss_pkg::SQ_W-1:0] n_x;
        logic [sss_pkg::SQ_W-1:0] n_y;

        always_comb begin
            b   = w_y[g] | M;
            n_y = w_y[g] >> 1;
            n_x = w_x[g];
            if (w_x[g] >= b) begin
                n_x = w_x[g] - b;
                n_y = n_y | M;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[g] <= w_v[g];
            end
            if (i_ctl.en) begin
                r_x[g]    <= n_x;
                r_y[g]    <= n_y;
                r_side[g] <= w_side[g];
            end
        end

        assign w_x[g+1]    = r_x[g];
        assign w_y[g+1]    = r_y[g];
        assign w_v[g+1]    = r_v[g];
        assign w_side[g+1] = r_side[g];
    end

    assign o_valid = w_v[N];
    assign o_root  = w_y[N][sss_pkg::D_W-1:0];
    assign o_side  = w_side[N];

endmodule

@@ rtl/sss_div.sv @@
// Needs sss_pkg. 4-lane pipelined restoring divider, one quotient bit per
// stage. Dividends >= 0; user must hold divisor during use, unchecked.
module sss_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  sss_pkg::t_ctl            i_ctl,
    input  logic                     i_valid,
    input  logic [sss_pkg::DIV_W-1:0] i_dvd [0:sss_pkg::LANES-1],
    input  logic [sss_pkg::RAD_W-1:0] i_divisor,
    output logic                     o_valid,
    output logic [sss_pkg::DIV_W-1:0] o_quo [0:sss_pkg::LANES-1]
);
    localparam int N  = sss_pkg::DIV_W;
    localparam int L  = sss_pkg::LANES;
    localparam int RW = sss_pkg::RAD_W;

    logic r_v [0:N-1];
    logic w_v [0:N];

    assign w_v[0] = i_valid;

    for (genvar s = 0; s < N; s++) begin : g_valid
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[s] <= 1'b0;
            end else if (i_ctl.en) begin
                r_v[s] <= w_v[s];
            end
        end
        assign w_v[s+1] = r_v[s];
    end

    for (genvar l = 0; l < L; l++) begin : g_lane
        logic [RW-1:0] r_rem [0:N-1];
        logic [N-1:0]  r_dvd [0:N-1];
        logic [N-1:0]  r_q   [0:N-1];
        logic [RW-1:0] w_rem [0:N];
        logic [N-1:0]  w_dvd [0:N];
        logic [N-1:0]  w_q   [0:N];

        assign w_rem[0] = '0;
        assign w_dvd[0] = i_dvd[l];
        assign w_q[0]   = '0;

        for (genvar s = 0; s < N; s++) begin : g_step
            logic [RW:0]   t;
            logic          ge;
            logic [RW:0]   diff;

            always_comb begin
                t    = {w_rem[s], w_dvd[s][N-1]};
                diff = t - {1'b0, i_divisor};
                ge   = (t >= {1'b0, i_divisor});
            end

            always_ff @(posedge i_clk) begin
                if (i_ctl.en) begin
                    r_rem[s] <= ge ? diff[RW-1:0] : t[RW-1:0];
                    r_dvd[s] <= {w_dvd[s][N-2:0], 1'b0};
                    r_q[s]   <= {w_q[s][N-2:0], ge};
                end
            end

            assign w_rem[s+1] = r_rem[s];
            assign w_dvd[s+1] = r_dvd[s];
            assign w_q[s+1]   = r_q[s];
        end

        assign o_quo[l] = w_q[N];
    end

    assign o_valid = w_v[N];

endmodule
